// ===== hdl/dqbs_pkg.sv =====
`timescale 1ns / 1ps

package dqbs_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_ADD_FRONT = 3'd0,
		CMD_ADD_BACK  = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_CONTAINS  = 3'd4,
		CMD_REM_VALUE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RD_FRONT,
		S_RD_BACK,
		S_FIN
	} state_t;

	typedef struct packed {
		status_t status;
		logic    found;
		logic    is_empty;
	} flags_t;

endpackage

// ===== hdl/dqbs_if.sv =====
`timescale 1ns / 1ps

interface dqbs_in_if import dqbs_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [2:0]                    command;
	logic signed [VALUE_WIDTH-1:0] item_value;

	modport source (output valid, output command, output item_value, input ready);
	modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface dqbs_out_if import dqbs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic                          found;
	logic signed [VALUE_WIDTH-1:0] front_value;
	logic signed [VALUE_WIDTH-1:0] back_value;
	logic [CNT_W-1:0]              entry_count;
	logic                          is_empty;

	modport source (output valid, output status, output found, output front_value,
		output back_value, output entry_count, output is_empty, input ready);
	modport sink   (input valid, input status, input found, input front_value,
		input back_value, input entry_count, input is_empty, output ready);
endinterface

// ===== hdl/dqbs_rsp_reg.sv =====
`timescale 1ns / 1ps

module dqbs_rsp_reg import dqbs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  flags_t                        flags,
	input  logic signed [VALUE_WIDTH-1:0] front,
	input  logic signed [VALUE_WIDTH-1:0] back,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	output logic                          free,
	dqbs_out_if.source                    response
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                          valid_q;
	flags_t                        flags_q;
	logic signed [VALUE_WIDTH-1:0] front_q;
	logic signed [VALUE_WIDTH-1:0] back_q;
	logic [CNT_W-1:0]              count_q;

	// a new word may enter when the slot is empty or drains this cycle
	assign free = !valid_q || response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (response.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_q <= flags;
			front_q <= front;
			back_q  <= back;
			count_q <= count;
		end
	end

	assign response.valid       = valid_q;
	assign response.status      = flags_q.status;
	assign response.found       = flags_q.found;
	assign response.is_empty    = flags_q.is_empty;
	assign response.front_value = front_q;
	assign response.back_value  = back_q;
	assign response.entry_count = count_q;

endmodule

// ===== hdl/deque_with_bag_search.sv =====
`timescale 1ns / 1ps

// channel    dir  payload
// request    in   command, item_value
// response   out  status, found, front_value, back_value, entry_count, is_empty
//
// one word at a time; the store is a single memory with one read and one write port
// add and end removals read the front, then the back, then finish; an empty store skips both reads
// contains/remove value scan one entry per cycle, remove value then moves the tail
// one entry per cycle toward the front
// reset clears head, count and the control state, no clearing pass over the memory
// a stalled response waits in its output register while the next word is processed

module deque_with_bag_search import dqbs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dqbs_in_if.sink    request,
	dqbs_out_if.source response
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
		if (sum >= (CNT_W+1)'(CAP_C)) begin
			sum = sum - (CNT_W+1)'(CAP_C);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [VALUE_WIDTH-1:0] mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] rdata_q;

	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       head_q, head_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [CNT_W-1:0]       pos_q, pos_d;
	logic [CNT_W-1:0]       cmp_pos_q, cmp_pos_d;
	logic                   cmp_vld_q, cmp_vld_d;
	logic [2:0]             cmd_q, cmd_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [VALUE_WIDTH-1:0] front_q, front_d;
	status_t                status_q, status_d;
	logic                   found_q, found_d;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   load;
	logic                   rsp_free;
	flags_t                 flags;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		pos_d     = pos_q;
		cmp_pos_d = cmp_pos_q;
		cmp_vld_d = cmp_vld_q;
		cmd_d     = cmd_q;
		val_d     = val_q;
		front_d   = front_q;
		status_d  = status_q;
		found_d   = found_q;
		rd_en     = 1'b0;
		rd_addr   = slot(head_q, pos_q);
		wr_en     = 1'b0;
		wr_addr   = slot(head_q, cmp_pos_q);
		wr_data   = rdata_q;
		load      = 1'b0;
		request.ready = 1'b0;

		case (state_q)
			S_IDLE: begin
				request.ready = 1'b1;
				if (request.valid) begin
					cmd_d     = request.command;
					val_d     = request.item_value;
					status_d  = ST_OK;
					found_d   = 1'b0;
					pos_d     = '0;
					cmp_vld_d = 1'b0;
					state_d   = S_RD_FRONT;
					case (request.command)
						CMD_ADD_FRONT, CMD_ADD_BACK: begin
							if (count_q == CAP_C) begin
								status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_data = request.item_value;
								count_d = count_q + 1'b1;
								if (request.command == CMD_ADD_FRONT) begin
									head_d  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
									wr_addr = head_d;
								end else begin
									wr_addr = slot(head_q, count_q);
								end
							end
						end
						CMD_REM_FRONT, CMD_REM_BACK: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
								if (request.command == CMD_REM_FRONT) begin
									head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
								end
							end
						end
						CMD_CONTAINS, CMD_REM_VALUE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				// read runs one entry ahead of the compare
				cmp_vld_d = pos_q < count_q;
				cmp_pos_d = pos_q;
				if (pos_q < count_q) begin
					rd_en = 1'b1;
					pos_d = pos_q + 1'b1;
				end
				if (cmp_vld_q && rdata_q == val_q) begin
					found_d   = 1'b1;
					cmp_vld_d = 1'b0;
					if (cmd_q == CMD_REM_VALUE) begin
						state_d   = S_SHIFT;
						pos_d     = cmp_pos_q + 1'b1;
						cmp_pos_d = cmp_pos_q;
					end else begin
						state_d = S_RD_FRONT;
					end
				end else if (!cmp_vld_q && pos_q >= count_q) begin
					state_d = S_RD_FRONT;
				end
			end
			S_SHIFT: begin
				// pos_q reads, cmp_pos_q writes one place toward the front
				cmp_vld_d = pos_q < count_q;
				if (pos_q < count_q) begin
					rd_en = 1'b1;
					pos_d = pos_q + 1'b1;
				end
				if (cmp_vld_q) begin
					wr_en     = 1'b1;
					cmp_pos_d = cmp_pos_q + 1'b1;
				end
				if (!cmp_vld_q && pos_q >= count_q) begin
					count_d = count_q - 1'b1;
					state_d = S_RD_FRONT;
				end
			end
			S_RD_FRONT: begin
				if (count_q == '0) begin
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = slot(head_q, '0);
					state_d = S_RD_BACK;
				end
			end
			S_RD_BACK: begin
				rd_en   = 1'b1;
				rd_addr = slot(head_q, count_q - 1'b1);
				front_d = rdata_q;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (rsp_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			pos_q     <= '0;
			cmp_pos_q <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			pos_q     <= pos_d;
			cmp_pos_q <= cmp_pos_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		val_q    <= val_d;
		front_q  <= front_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign flags.status   = status_q;
	assign flags.found    = found_q;
	assign flags.is_empty = count_q == '0;

	dqbs_rsp_reg #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_rsp_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.flags    (flags),
		.front    ((count_q == '0) ? '0 : front_q),
		.back     ((count_q == '0) ? '0 : rdata_q),
		.count    (count_q),
		.free     (rsp_free),
		.response (response)
	);

endmodule

// ===== hdl/dqbs_checker.sv =====
`timescale 1ns / 1ps

module dqbs_checker import dqbs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [1:0]                    rsp_status,
	input logic                          rsp_found,
	input logic signed [VALUE_WIDTH-1:0] rsp_front,
	input logic signed [VALUE_WIDTH-1:0] rsp_back,
	input logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count,
	input logic                          rsp_is_empty
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
			&& $stable(rsp_front) && $stable(rsp_back) && $stable(rsp_entry_count))
		else $error("response changed while stalled");

	// one word in flight: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_is_empty == (rsp_entry_count == '0)
			&& rsp_entry_count <= ($clog2(CAPACITY+1))'(CAPACITY))
		else $error("count and empty flag disagree");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |-> rsp_front == '0 && rsp_back == '0)
		else $error("empty store reports values");

	a_empty_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
			|-> !rsp_found && (rsp_status == ST_FULL || rsp_is_empty))
		else $error("error status inconsistent with store");

endmodule

bind deque_with_bag_search dqbs_checker #(
	.CAPACITY    (CAPACITY),
	.VALUE_WIDTH (VALUE_WIDTH)
) u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (request.valid),
	.req_ready       (request.ready),
	.rsp_valid       (response.valid),
	.rsp_ready       (response.ready),
	.rsp_status      (response.status),
	.rsp_found       (response.found),
	.rsp_front       (response.front_value),
	.rsp_back        (response.back_value),
	.rsp_entry_count (response.entry_count),
	.rsp_is_empty    (response.is_empty)
);
